@@ rtl/c2p_pkg.sv @@
// ----------------------------------------------------------------------------
// c2p_pkg
// shared constants for the cartesian to polar cordic pipeline
// ----------------------------------------------------------------------------
package c2p_pkg;

  // fractional guard bits below the coordinate lsb
  localparam int unsigned GUARD_BITS = 4;

  // width of the angle accumulator, a fraction of a full turn
  localparam int unsigned ZW = 32;

  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

  // reciprocal cordic gain as a 0.32 fraction, split in two 16-bit halves
  localparam logic [15:0] INV_GAIN_HI = 16'h9B74;
  localparam logic [15:0] INV_GAIN_LO = 16'hEDA8;

  localparam int unsigned MAX_STAGES = 32;

  // atan(2^-i) / (2 pi) * 2^32, rounded to nearest
  localparam logic [ZW-1:0] ATAN_TURN [MAX_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

@@ rtl/c2p_prep.sv @@
// ----------------------------------------------------------------------------
// c2p_prep
// input stage: folds the left half plane and scales in the guard bits
// ----------------------------------------------------------------------------
module c2p_prep #(
  parameter int unsigned CW = 16,
  parameter int unsigned XW = 22
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_zero,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic [c2p_pkg::ZW-1:0] out_z
);
  import c2p_pkg::*;

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic [ZW-1:0]        z_next;
  logic                 zero_next;

  always_comb begin
    x_ext     = XW'(in_x);
    y_ext     = XW'(in_y);
    zero_next = (in_x == '0) && (in_y == '0);
    if (in_x[CW-1]) begin
      // turn by half a turn into the right half plane
      x_next = (-x_ext) <<< GUARD_BITS;
      y_next = (-y_ext) <<< GUARD_BITS;
      z_next = HALF_TURN;
    end else begin
      x_next = x_ext <<< GUARD_BITS;
      y_next = y_ext <<< GUARD_BITS;
      z_next = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_zero <= zero_next;
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
    end
  end

endmodule

@@ rtl/c2p_stage.sv @@
// ----------------------------------------------------------------------------
// c2p_stage
// one cordic micro-rotation in vectoring mode, registered
// ----------------------------------------------------------------------------
module c2p_stage #(
  parameter int unsigned XW    = 22,
  parameter int unsigned SHIFT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_zero,
  input  logic signed [XW-1:0]   in_x,
  input  logic signed [XW-1:0]   in_y,
  input  logic [c2p_pkg::ZW-1:0] in_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_zero,
  output logic signed [XW-1:0]   out_x,
  output logic signed [XW-1:0]   out_y,
  output logic [c2p_pkg::ZW-1:0] out_z
);
  import c2p_pkg::*;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic [ZW-1:0]        z_next;

  always_comb begin
    dx = in_y >>> SHIFT;
    dy = in_x >>> SHIFT;
    // rotate toward the x axis, direction from the sign of y
    if (!in_y[XW-1]) begin
      x_next = in_x + dx;
      y_next = in_y - dy;
      z_next = in_z + ATAN_TURN[SHIFT];
    end else begin
      x_next = in_x - dx;
      y_next = in_y + dy;
      z_next = in_z - ATAN_TURN[SHIFT];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_zero <= in_zero;
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
    end
  end

endmodule

@@ rtl/c2p_gain.sv @@
// ----------------------------------------------------------------------------
// c2p_gain
// gain correction, saturation and rounding: two partial products, then sum and round
// ----------------------------------------------------------------------------
module c2p_gain #(
  parameter int unsigned CW = 16,
  parameter int unsigned AW = 16,
  parameter int unsigned XW = 22
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_zero,
  input  logic signed [XW-1:0]   in_x,
  input  logic [c2p_pkg::ZW-1:0] in_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CW-1:0]          out_radius,
  output logic [AW-1:0]          out_angle
);
  import c2p_pkg::*;

  localparam int unsigned MW = XW - 1;   // magnitude bits, x is never negative
  localparam int unsigned PW = MW + 16;  // partial product width
  localparam int unsigned RW = PW + 1 - (16 + GUARD_BITS);

  // product stage
  logic          prod_valid;
  logic          prod_ready;
  logic          prod_zero;
  logic [PW-1:0] p_hi;
  logic [PW-1:0] p_lo;
  logic [ZW-1:0] prod_z;
  logic [MW-1:0] xm;

  // rounding
  logic [PW:0]   t16;
  logic [PW:0]   t_rnd;
  logic [RW-1:0] rad_full;
  logic [CW-1:0] radius_next;
  logic [AW-1:0] angle_next;
  logic [AW-1:0] angle_round;

  assign xm = in_x[MW-1:0];

  assign in_ready = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_zero <= in_zero;
      p_hi      <= PW'(xm) * PW'(INV_GAIN_HI);
      p_lo      <= PW'(xm) * PW'(INV_GAIN_LO);
      prod_z    <= in_z;
    end
  end

  generate
    if (AW < ZW) begin : g_round
      localparam int unsigned SH = ZW - AW;
      logic [ZW:0] z_sum;
      // round half up, a full turn wraps to zero
      assign z_sum       = {1'b0, prod_z} + ((ZW + 1)'(1) << (SH - 1));
      assign angle_round = z_sum[SH +: AW];
    end else begin : g_exact
      assign angle_round = prod_z[AW-1:0];
    end
  endgenerate

  always_comb begin
    t16      = (PW + 1)'(p_hi) + (PW + 1)'(p_lo[PW-1:16]);
    t_rnd    = t16 + ((PW + 1)'(1) << (15 + GUARD_BITS));
    rad_full = t_rnd[PW:16 + GUARD_BITS];
    if (rad_full > RW'({CW{1'b1}})) begin
      radius_next = '1;
    end else begin
      radius_next = rad_full[CW-1:0];
    end
    angle_next = angle_round;
    if (prod_zero) begin
      radius_next = '0;
      angle_next  = '0;
    end
  end

  assign prod_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      out_radius <= radius_next;
      out_angle  <= angle_next;
    end
  end

endmodule

@@ rtl/cartesian_to_polar_unit.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_polar_unit
// pipelined cordic converting signed cartesian points to radius and angle
// ----------------------------------------------------------------------------
// Takes one signed point per cycle when not stalled and returns its distance
// from the origin and its angle, counterclockwise from the positive x axis,
// as a fraction of a full turn (2^ANGLE_WIDTH equals 2 pi). The datapath is
// a fully unrolled cordic: one input stage that folds the left half plane
// onto the right, ITERATIONS micro-rotation stages, and two gain stages
// (partial products, then sum, round and saturate). Every stage is a register
// with its own valid bit, so one item enters and one leaves per cycle at full
// rate. Back-pressure collapses bubbles: a stage takes a new item whenever it
// is empty or its successor takes its item, so input is still accepted while
// a finished result waits at the output, as long as there are empty stages.
// The origin gives radius 0 and angle 0; the radius saturates at all ones.
// ----------------------------------------------------------------------------
module cartesian_to_polar_unit #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH = 16,
  parameter int unsigned ITERATIONS  = 16
) (
  input  logic clk,
  input  logic rst,
  // input items
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // [COORD_WIDTH-1:0] x_coord, [2*COORD_WIDTH-1:COORD_WIDTH] y_coord, zero fill
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
  // result items
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // [COORD_WIDTH-1:0] radius, then angle above it, zero fill
  output logic [((COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] m_tdata
);
  import c2p_pkg::*;

  localparam int unsigned IN_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
  // datapath width: guard bits plus headroom for sqrt(2) and the cordic gain
  localparam int unsigned XW    = COORD_WIDTH + GUARD_BITS + 2;

  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic [COORD_WIDTH-1:0]        radius;
  logic [ANGLE_WIDTH-1:0]        angle;

  // stage k output feeds stage k+1; index 0 is the input stage
  logic                 vld  [ITERATIONS+1];
  logic                 rdy  [ITERATIONS+1];
  logic                 zero [ITERATIONS+1];
  logic signed [XW-1:0] sx   [ITERATIONS+1];
  logic signed [XW-1:0] sy   [ITERATIONS+1];
  logic [ZW-1:0]        sz   [ITERATIONS+1];

  assign x_coord = s_tdata[COORD_WIDTH-1:0];
  assign y_coord = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

  c2p_prep #(
    .CW (COORD_WIDTH),
    .XW (XW)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (x_coord),
    .in_y      (y_coord),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_zero  (zero[0]),
    .out_x     (sx[0]),
    .out_y     (sy[0]),
    .out_z     (sz[0])
  );

  // one micro-rotation per stage, shift and table entry fixed by position
  generate
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
      c2p_stage #(
        .XW    (XW),
        .SHIFT (i)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (vld[i]),
        .in_ready  (rdy[i]),
        .in_zero   (zero[i]),
        .in_x      (sx[i]),
        .in_y      (sy[i]),
        .in_z      (sz[i]),
        .out_valid (vld[i+1]),
        .out_ready (rdy[i+1]),
        .out_zero  (zero[i+1]),
        .out_x     (sx[i+1]),
        .out_y     (sy[i+1]),
        .out_z     (sz[i+1])
      );
    end
  endgenerate

  // y has been driven to zero; only x and the angle go on
  c2p_gain #(
    .CW (COORD_WIDTH),
    .AW (ANGLE_WIDTH),
    .XW (XW)
  ) u_gain (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (vld[ITERATIONS]),
    .in_ready   (rdy[ITERATIONS]),
    .in_zero    (zero[ITERATIONS]),
    .in_x       (sx[ITERATIONS]),
    .in_z       (sz[ITERATIONS]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_radius (radius),
    .out_angle  (angle)
  );

  // result packing, radius in the low bits
  assign m_tdata = OUT_W'({angle, radius});

  // sy of the last stage is the residual and not needed further
  logic unused_y;
  assign unused_y = ^{sy[ITERATIONS], s_tdata[IN_W-1:2*COORD_WIDTH-1]};

endmodule

@@ rtl/c2p_checker.sv @@
// ----------------------------------------------------------------------------
// c2p_checker
// port-level checks of the cartesian to polar pipeline
// ----------------------------------------------------------------------------
module c2p_checker #(
  parameter int unsigned OUT_W = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // with the output free every stage can move, so input is always taken
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while the output is free");

  // an idle input and a free output cannot stall the input next cycle
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tvalid && !m_tvalid ##1 m_tready |-> s_tready)
    else $error("input stalled with no work queued");

endmodule

bind cartesian_to_polar_unit c2p_checker #(
  .OUT_W (OUT_W)
) u_c2p_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
